>>> src/lkvc_pkg.sv
// Shared constants for the LRU key-value cache.
`default_nettype none

package lkvc_pkg;

  localparam int FIELD_BITS     = 32;
  localparam int CAP_BITS       = 5;
  localparam int CAP_RESET      = 16;
  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_KEY_BITS   = 32;
  localparam int DEF_VALUE_BITS = 32;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

endpackage

`default_nettype wire

>>> src/lkvc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module lkvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> src/lru_key_value_cache.sv
// Top level of the fully associative key-value cache with LRU replacement.
// Result: registered in the decide step after a scan of all entries, later while a prior
//   result is stalled. Requests stall until idle; a get miss frees the engine after the
//   decide step, while a get hit or any put also needs a second pass over the rank memory
//   port (a lookup scan, then a re-rank pass once the old rank of the target is known).
// Reset: synchronous, clears valid bits, entry count and handshake state, and
//   sets capacity to 16; a capacity write clears the store the same way.
`default_nettype none

module lru_key_value_cache #(
  parameter int ENTRIES    = lkvc_pkg::DEF_ENTRIES,
  parameter int KEY_BITS   = lkvc_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = lkvc_pkg::DEF_VALUE_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // request channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              mode,
  input  wire logic [lkvc_pkg::FIELD_BITS-1:0]   lookup_key,
  input  wire logic [lkvc_pkg::FIELD_BITS-1:0]   write_value,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   found,
  output logic      [lkvc_pkg::FIELD_BITS-1:0]   read_value,
  // capacity register write
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [lkvc_pkg::CAP_BITS-1:0]     cfg_data
);

  localparam int FB       = lkvc_pkg::FIELD_BITS;
  localparam int CB       = lkvc_pkg::CAP_BITS;
  localparam int IDX_BITS = $clog2(ENTRIES);
  localparam int CNT_BITS = $clog2(ENTRIES + 1);
  localparam int CMP_BITS = (CNT_BITS > CB) ? CNT_BITS : CB;
  // Only the low bits of the 32-bit fields ever matter, so store no more than that.
  localparam int KS       = (KEY_BITS < FB) ? KEY_BITS : FB;
  localparam int VS       = (VALUE_BITS < FB) ? VALUE_BITS : FB;
  localparam int KV_BITS  = KS + VS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_PROMOTE
  } state_t;

  // Clip a written capacity: zero acts as one, anything above the depth as the depth.
  function automatic logic [CMP_BITS-1:0] clip_cap(input logic [CB-1:0] v);
    logic [CMP_BITS-1:0] w;
    w = CMP_BITS'(v);
    if (v == '0) begin
      w = CMP_BITS'(1);
    end else if (w > CMP_BITS'(ENTRIES)) begin
      w = CMP_BITS'(ENTRIES);
    end
    return w;
  endfunction

  state_t               state;
  logic [ENTRIES-1:0]   valid;
  logic [CNT_BITS-1:0]  count;
  logic [CMP_BITS-1:0]  eff_cap;

  // captured request
  logic                 req_mode;
  logic [KS-1:0]        req_key;
  logic [VS-1:0]        req_value;

  // pass sequencing: idx issues reads, rd_idx tags the data that comes back
  logic [CNT_BITS-1:0]  idx;
  logic                 rd_live;
  logic [IDX_BITS-1:0]  rd_idx;

  // scan findings
  logic                 hit_found;
  logic [IDX_BITS-1:0]  hit_idx;
  logic [VS-1:0]        hit_value;
  logic [IDX_BITS-1:0]  hit_rank;
  logic                 free_found;
  logic [IDX_BITS-1:0]  free_idx;
  logic                 lru_found;
  logic [IDX_BITS-1:0]  lru_idx;
  logic [IDX_BITS-1:0]  lru_rank;

  // re-rank target: the promoted slot and its rank before promotion
  logic [IDX_BITS-1:0]  slot;
  logic [CNT_BITS-1:0]  old_rank;

  // RAM ports
  logic                 kv_we;
  logic [IDX_BITS-1:0]  kv_waddr;
  logic [KV_BITS-1:0]   kv_wdata;
  logic                 kv_re;
  logic [KV_BITS-1:0]   kv_rdata;
  logic                 rank_we;
  logic [IDX_BITS-1:0]  rank_wdata;
  logic                 rank_re;
  logic [IDX_BITS-1:0]  rank_rdata;
  logic [IDX_BITS-1:0]  rd_addr;

  // decide-step terms
  logic                 issue;
  logic                 in_take;
  logic                 cfg_take;
  logic                 out_free;
  logic                 use_free;
  logic                 target_ok;
  logic [IDX_BITS-1:0]  target_idx;
  logic [CNT_BITS-1:0]  target_old;
  logic                 rd_entry_valid;
  logic [KS-1:0]        rd_key;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_take  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid || !out_stall;

  assign issue   = (idx < CNT_BITS'(ENTRIES));
  assign rd_addr = idx[IDX_BITS-1:0];
  assign rd_key  = kv_rdata[KV_BITS-1:VS];
  assign rd_entry_valid = valid[rd_idx];

  always_comb begin
    // Fill a free slot while under capacity; otherwise reuse the least recent one.
    use_free   = !hit_found && (CMP_BITS'(count) < eff_cap) && free_found;
    target_ok  = hit_found || use_free || lru_found;
    target_idx = lru_idx;
    target_old = CNT_BITS'(lru_rank);
    if (hit_found) begin
      target_idx = hit_idx;
      target_old = CNT_BITS'(hit_rank);
    end else if (use_free) begin
      target_idx = free_idx;
      target_old = CNT_BITS'(ENTRIES);
    end
  end

  always_comb begin
    kv_re    = (state == ST_SCAN) && issue;
    rank_re  = ((state == ST_SCAN) || (state == ST_PROMOTE)) && issue;
    kv_we    = (state == ST_DECIDE) && out_free && (req_mode == lkvc_pkg::MODE_PUT)
               && target_ok;
    kv_waddr = target_idx;
    kv_wdata = {req_key, req_value};
    // Entries more recent than the target age by one; the target itself drops to rank zero.
    rank_we  = (state == ST_PROMOTE) && rd_live &&
               ((rd_idx == slot) ||
                (rd_entry_valid && (CNT_BITS'(rank_rdata) < old_rank)));
    rank_wdata = (rd_idx == slot) ? '0 : (rank_rdata + IDX_BITS'(1));
  end

  lkvc_ram #(
    .WIDTH (KV_BITS),
    .DEPTH (ENTRIES)
  ) u_kv_ram (
    .clk     (clk),
    .wr_en   (kv_we),
    .wr_addr (kv_waddr),
    .wr_data (kv_wdata),
    .rd_en   (kv_re),
    .rd_addr (rd_addr),
    .rd_data (kv_rdata)
  );

  lkvc_ram #(
    .WIDTH (IDX_BITS),
    .DEPTH (ENTRIES)
  ) u_rank_ram (
    .clk     (clk),
    .wr_en   (rank_we),
    .wr_addr (rd_idx),
    .wr_data (rank_wdata),
    .rd_en   (rank_re),
    .rd_addr (rd_addr),
    .rd_data (rank_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      valid     <= '0;
      count     <= '0;
      eff_cap   <= clip_cap(CB'(lkvc_pkg::CAP_RESET));
      out_valid <= 1'b0;
      rd_live   <= 1'b0;
      idx       <= '0;
    end else begin
      // Drop the result once the consumer takes it; the decide step loads its own.
      if (out_valid && !out_stall && (state != ST_DECIDE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (cfg_take) begin
            eff_cap <= clip_cap(cfg_data);
            valid   <= '0;
            count   <= '0;
          end
          if (in_take) begin
            req_mode   <= mode;
            req_key    <= KS'(lookup_key);
            req_value  <= VS'(write_value);
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            lru_found  <= 1'b0;
            idx        <= '0;
            rd_live    <= 1'b0;
            state      <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          if (issue) begin
            idx <= idx + CNT_BITS'(1);
          end
          rd_live <= issue;
          rd_idx  <= rd_addr;
          if (rd_live) begin
            // Keep the first match of each kind, in slot order.
            if (rd_entry_valid && (rd_key == req_key) && !hit_found) begin
              hit_found <= 1'b1;
              hit_idx   <= rd_idx;
              hit_value <= kv_rdata[VS-1:0];
              hit_rank  <= rank_rdata;
            end
            if (!rd_entry_valid && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= rd_idx;
            end
            if (rd_entry_valid && !lru_found &&
                ((CNT_BITS'(rank_rdata) + CNT_BITS'(1)) == count)) begin
              lru_found <= 1'b1;
              lru_idx   <= rd_idx;
              lru_rank  <= rank_rdata;
            end
          end
          if (!issue && rd_live) begin
            state <= ST_DECIDE;
          end
        end

        ST_DECIDE: begin
          // Hold until the result register can take the outcome.
          if (out_free) begin
            out_valid  <= 1'b1;
            found      <= hit_found;
            read_value <= (hit_found && (req_mode == lkvc_pkg::MODE_GET))
                          ? FB'(hit_value) : '0;
            slot       <= target_idx;
            old_rank   <= target_old;
            idx        <= '0;
            rd_live    <= 1'b0;
            if ((req_mode == lkvc_pkg::MODE_GET) && !hit_found) begin
              state <= ST_IDLE;
            end else if (!target_ok) begin
              state <= ST_IDLE;
            end else begin
              if (use_free) begin
                count <= count + CNT_BITS'(1);
              end
              valid[target_idx] <= 1'b1;
              state <= ST_PROMOTE;
            end
          end
        end

        ST_PROMOTE: begin
          if (issue) begin
            idx <= idx + CNT_BITS'(1);
          end
          rd_live <= issue;
          rd_idx  <= rd_addr;
          if (!issue && rd_live) begin
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Valid bits and the fill count track each other.
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == count)
    else $error("entry count disagrees with valid bits");

  // The store never holds more entries than the clipped capacity.
  a_count_within_cap: assert property (@(posedge clk) disable iff (rst)
    CMP_BITS'(count) <= eff_cap)
    else $error("entry count above capacity");

  // A capacity write empties the store.
  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_take |=> (valid == '0) && (count == '0))
    else $error("capacity write did not clear the store");

  // Ranks are rewritten only during the re-rank pass.
  a_rank_write_in_promote: assert property (@(posedge clk) disable iff (rst)
    rank_we |-> (state == ST_PROMOTE) && rd_live)
    else $error("rank write outside re-rank pass");

endmodule

`default_nettype wire
